FILE: sv/pair_force_virial_accumulator_unit_macros.svh
// assertion macros shared by the checker of the force and virial accumulator
`ifndef PAIR_FORCE_VIRIAL_ACCUMULATOR_UNIT_MACROS_SVH
`define PAIR_FORCE_VIRIAL_ACCUMULATOR_UNIT_MACROS_SVH

// concurrent check, switched off while reset is low
`define PFVA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pfva check failed");

// concurrent check that also runs across reset
`define PFVA_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("pfva check failed");

`endif

FILE: sv/pfva_pkg.sv
// types, constants and saturating helpers of the force and virial accumulator
`default_nettype none

package pfva_pkg;

  localparam int ATOM_COUNT_DEF = 4096;
  localparam int IDX_W          = 12;
  localparam int IDX_SPAN       = 1 << IDX_W;
  localparam int D_W            = 32;
  localparam int FORCE_W        = 48;
  localparam int VIR_W          = 64;
  localparam int VIR_N          = 6;
  localparam int QUEUE_DEPTH    = 2;

  // virial component order
  localparam int VIR_XX = 0;
  localparam int VIR_YY = 1;
  localparam int VIR_ZZ = 2;
  localparam int VIR_XY = 3;
  localparam int VIR_XZ = 4;
  localparam int VIR_YZ = 5;

  typedef enum logic [1:0] {
    CMD_NEIGH     = 2'd0,
    CMD_FORCE_RD  = 2'd1,
    CMD_VIRIAL_RD = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]             cmd;
    logic signed [D_W-1:0]  dx;
    logic signed [D_W-1:0]  dy;
    logic signed [D_W-1:0]  dz;
    logic signed [D_W-1:0]  grad_x;
    logic signed [D_W-1:0]  grad_y;
    logic signed [D_W-1:0]  grad_z;
    logic [IDX_W-1:0]       atom_index;
    logic [IDX_W-1:0]       center_index;
    logic                   last;
  } in_item_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic signed [FORCE_W-1:0] force_z;
    logic signed [VIR_W-1:0]   virial_xx;
    logic signed [VIR_W-1:0]   virial_yy;
    logic signed [VIR_W-1:0]   virial_zz;
    logic signed [VIR_W-1:0]   virial_xy;
    logic signed [VIR_W-1:0]   virial_xz;
    logic signed [VIR_W-1:0]   virial_yz;
  } out_item_t;

  // classified item as it waits for the back end
  typedef struct packed {
    cmd_e                   cmd;
    logic signed [D_W-1:0]  dx;
    logic signed [D_W-1:0]  dy;
    logic signed [D_W-1:0]  dz;
    logic signed [D_W-1:0]  grad_x;
    logic signed [D_W-1:0]  grad_y;
    logic signed [D_W-1:0]  grad_z;
    logic [IDX_W-1:0]       atom_index;
    logic [IDX_W-1:0]       center_index;
    logic                   atom_ok;
    logic                   center_ok;
    logic                   last;
  } work_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] x;
    logic signed [FORCE_W-1:0] y;
    logic signed [FORCE_W-1:0] z;
  } force_word_t;

  function automatic logic signed [FORCE_W-1:0] clamp_force(
    input logic signed [FORCE_W:0] v
  );
    if (v[FORCE_W] != v[FORCE_W-1]) begin
      return v[FORCE_W] ? {1'b1, {(FORCE_W-1){1'b0}}} : {1'b0, {(FORCE_W-1){1'b1}}};
    end
    return v[FORCE_W-1:0];
  endfunction

  function automatic logic signed [FORCE_W-1:0] force_add(
    input logic signed [FORCE_W-1:0] a,
    input logic signed [FORCE_W-1:0] b
  );
    return clamp_force((FORCE_W+1)'(a) + (FORCE_W+1)'(b));
  endfunction

  function automatic logic signed [FORCE_W-1:0] force_add_grad(
    input logic signed [FORCE_W-1:0] a,
    input logic signed [D_W-1:0]     g
  );
    return clamp_force((FORCE_W+1)'(a) + (FORCE_W+1)'(g));
  endfunction

  function automatic logic signed [FORCE_W-1:0] force_sub_grad(
    input logic signed [FORCE_W-1:0] a,
    input logic signed [D_W-1:0]     g
  );
    return clamp_force((FORCE_W+1)'(a) - (FORCE_W+1)'(g));
  endfunction

  function automatic logic signed [VIR_W-1:0] vir_sub(
    input logic signed [VIR_W-1:0] a,
    input logic signed [VIR_W-1:0] b
  );
    logic signed [VIR_W:0] d;
    d = (VIR_W+1)'(a) - (VIR_W+1)'(b);
    if (d[VIR_W] != d[VIR_W-1]) begin
      return d[VIR_W] ? {1'b1, {(VIR_W-1){1'b0}}} : {1'b0, {(VIR_W-1){1'b1}}};
    end
    return d[VIR_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/pfva_fifo.sv
// small first-in first-out queue for items of any packed type
`default_nettype none

module pfva_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = pfva_pkg::QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              store_q [DEPTH];
  logic [PW-1:0] wr_q;
  logic [PW-1:0] rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push;
  logic          do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/pfva_front.sv
// front end: takes input items, classifies them and queues them for the back end
`default_nettype none

module pfva_front #(
  parameter int ATOM_COUNT = pfva_pkg::ATOM_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pfva_pkg::in_item_t  item_i,
  output logic                full_o,
  input  pfva_pkg::back_ctl_t ctl_i,
  output pfva_pkg::work_t     work_o,
  output logic                work_empty_o
);

  import pfva_pkg::*;

  work_t cls;
  logic  q_full;
  logic  accept;

  always_comb begin
    cls.cmd          = cmd_e'(item_i.cmd);
    cls.dx           = item_i.dx;
    cls.dy           = item_i.dy;
    cls.dz           = item_i.dz;
    cls.grad_x       = item_i.grad_x;
    cls.grad_y       = item_i.grad_y;
    cls.grad_z       = item_i.grad_z;
    cls.atom_index   = item_i.atom_index;
    cls.center_index = item_i.center_index;
    // indices past the store are never written and read back as zero
    cls.atom_ok      = (32'(item_i.atom_index) < ATOM_COUNT);
    cls.center_ok    = (32'(item_i.center_index) < ATOM_COUNT);
    cls.last         = item_i.last;
  end

  // nothing enters while the force store is being swept after reset
  assign full_o = q_full || ctl_i.clearing;
  assign accept = push_i && !full_o;

  pfva_fifo #(
    .T     (work_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_work_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (cls),
    .full_o  (q_full),
    .pop_i   (ctl_i.pop),
    .data_o  (work_o),
    .empty_o (work_empty_o)
  );

endmodule

`default_nettype wire

FILE: sv/pfva_back.sv
// back end: force store, centre sums and virial, driven by a small sequencer
`default_nettype none

module pfva_back #(
  parameter int ATOM_COUNT = pfva_pkg::ATOM_COUNT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pfva_pkg::work_t      work_i,
  input  logic                 work_empty_i,
  output pfva_pkg::back_ctl_t  ctl_o,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output pfva_pkg::out_item_t  res_o
);

  import pfva_pkg::*;

  // indices are IDX_W bits wide, so entries past IDX_SPAN are never reached
  localparam int DEPTH = (ATOM_COUNT < IDX_SPAN) ? ATOM_COUNT : IDX_SPAN;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NB_WR,
    ST_C_RD,
    ST_C_WR,
    ST_FR_WR
  } state_e;

  state_e                    state_q;
  logic [AW-1:0]             clr_cnt_q;
  work_t                     cur_q;
  logic signed [VIR_W-1:0]   prod_q [VIR_N];
  logic signed [VIR_W-1:0]   vir_q  [VIR_N];
  logic signed [FORCE_W-1:0] csum_x_q;
  logic signed [FORCE_W-1:0] csum_y_q;
  logic signed [FORCE_W-1:0] csum_z_q;

  force_word_t               mem [DEPTH];
  force_word_t               rdata_q;
  force_word_t               mem_wdata;
  logic [AW-1:0]             mem_addr;
  logic                      mem_we;
  logic                      mem_re;
  logic                      start;

  assign start = (state_q == ST_IDLE) && !work_empty_i && !res_full_i;

  always_comb begin
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = '0;
    mem_wdata      = '0;
    res_push_o     = 1'b0;
    res_o          = '0;
    ctl_o.pop      = start;
    ctl_o.clearing = (state_q == ST_CLEAR);
    case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt_q;
      end
      ST_IDLE: begin
        if (start) begin
          case (work_i.cmd)
            CMD_NEIGH, CMD_FORCE_RD: begin
              mem_re   = work_i.atom_ok;
              mem_addr = work_i.atom_index[AW-1:0];
            end
            CMD_VIRIAL_RD: begin
              res_push_o      = 1'b1;
              res_o.virial_xx = vir_q[VIR_XX];
              res_o.virial_yy = vir_q[VIR_YY];
              res_o.virial_zz = vir_q[VIR_ZZ];
              res_o.virial_xy = vir_q[VIR_XY];
              res_o.virial_xz = vir_q[VIR_XZ];
              res_o.virial_yz = vir_q[VIR_YZ];
            end
            default: begin
              res_push_o = 1'b1;
            end
          endcase
        end
      end
      ST_NB_WR: begin
        mem_we      = cur_q.atom_ok;
        mem_addr    = cur_q.atom_index[AW-1:0];
        mem_wdata.x = force_sub_grad(rdata_q.x, cur_q.grad_x);
        mem_wdata.y = force_sub_grad(rdata_q.y, cur_q.grad_y);
        mem_wdata.z = force_sub_grad(rdata_q.z, cur_q.grad_z);
        res_push_o  = !cur_q.last;
      end
      ST_C_RD: begin
        mem_re   = cur_q.center_ok;
        mem_addr = cur_q.center_index[AW-1:0];
      end
      ST_C_WR: begin
        mem_we      = cur_q.center_ok;
        mem_addr    = cur_q.center_index[AW-1:0];
        mem_wdata.x = force_add(rdata_q.x, csum_x_q);
        mem_wdata.y = force_add(rdata_q.y, csum_y_q);
        mem_wdata.z = force_add(rdata_q.z, csum_z_q);
        res_push_o  = 1'b1;
      end
      ST_FR_WR: begin
        mem_we     = cur_q.atom_ok;
        mem_addr   = cur_q.atom_index[AW-1:0];
        res_push_o = 1'b1;
        if (cur_q.atom_ok) begin
          res_o.force_x = rdata_q.x;
          res_o.force_y = rdata_q.y;
          res_o.force_z = rdata_q.z;
        end
      end
      default: ;
    endcase
  end

  // single-port force store with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      cur_q          <= work_i;
      prod_q[VIR_XX] <= work_i.dx * work_i.grad_x;
      prod_q[VIR_YY] <= work_i.dy * work_i.grad_y;
      prod_q[VIR_ZZ] <= work_i.dz * work_i.grad_z;
      prod_q[VIR_XY] <= work_i.dx * work_i.grad_y;
      prod_q[VIR_XZ] <= work_i.dx * work_i.grad_z;
      prod_q[VIR_YZ] <= work_i.dy * work_i.grad_z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      csum_x_q  <= '0;
      csum_y_q  <= '0;
      csum_z_q  <= '0;
      for (int k = 0; k < VIR_N; k++) begin
        vir_q[k] <= '0;
      end
    end else begin
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == AW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            case (work_i.cmd)
              CMD_NEIGH:    state_q <= ST_NB_WR;
              CMD_FORCE_RD: state_q <= ST_FR_WR;
              CMD_VIRIAL_RD: begin
                for (int k = 0; k < VIR_N; k++) begin
                  vir_q[k] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_NB_WR: begin
          csum_x_q <= force_add_grad(csum_x_q, cur_q.grad_x);
          csum_y_q <= force_add_grad(csum_y_q, cur_q.grad_y);
          csum_z_q <= force_add_grad(csum_z_q, cur_q.grad_z);
          for (int k = 0; k < VIR_N; k++) begin
            vir_q[k] <= vir_sub(vir_q[k], prod_q[k]);
          end
          state_q <= cur_q.last ? ST_C_RD : ST_IDLE;
        end
        ST_C_RD: begin
          state_q <= ST_C_WR;
        end
        ST_C_WR: begin
          csum_x_q <= '0;
          csum_y_q <= '0;
          csum_z_q <= '0;
          state_q  <= ST_IDLE;
        end
        ST_FR_WR: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/pair_force_virial_accumulator_unit.sv
// top level of the pairwise force and virial accumulator
`default_nettype none

// Accumulates neighbour gradients into a per-atom force store and a six-part
// virial, in saturating fixed point, and answers every item with exactly one
// result, in order, through a two-deep result queue. Items are served one at a
// time by the back end; their cost is set by the single-port force store, where
// each force update is a read followed by a write: a neighbour item updates its
// atom, and when it is marked last then also its centre (neighbour then centre
// update), a force read reads its atom and clears it, and a virial read or an
// unused command leaves the store alone. A two-deep queue sits between the input
// and the back end. After reset the force store is swept to zero, one entry a
// cycle, over all min(ATOM_COUNT, 4096) entries; full stays high until it ends.
module pair_force_virial_accumulator_unit #(
  parameter int ATOM_COUNT = pfva_pkg::ATOM_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  pfva_pkg::in_item_t  item_i,
  output logic                empty,
  input  logic                pop,
  output pfva_pkg::out_item_t result_o
);

  import pfva_pkg::*;

  back_ctl_t ctl;
  work_t     work;
  logic      work_empty;
  logic      res_full;
  logic      res_push;
  out_item_t res;

  pfva_front #(
    .ATOM_COUNT (ATOM_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (item_i),
    .full_o       (full),
    .ctl_i        (ctl),
    .work_o       (work),
    .work_empty_o (work_empty)
  );

  pfva_back #(
    .ATOM_COUNT (ATOM_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_i       (work),
    .work_empty_i (work_empty),
    .ctl_o        (ctl),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  pfva_fifo #(
    .T     (out_item_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

FILE: sv/pfva_checker.sv
// port-level checks of the force and virial accumulator, bound to the top level
`default_nettype none

`include "pair_force_virial_accumulator_unit_macros.svh"

module pfva_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                full,
  input  logic                empty,
  input  logic                pop,
  input  pfva_pkg::out_item_t result_o
);

  import pfva_pkg::*;

  logic force_zero;
  logic virial_zero;

  assign force_zero  = (result_o.force_x == '0) && (result_o.force_y == '0) &&
                       (result_o.force_z == '0);
  assign virial_zero = (result_o.virial_xx == '0) && (result_o.virial_yy == '0) &&
                       (result_o.virial_zz == '0) && (result_o.virial_xy == '0) &&
                       (result_o.virial_xz == '0) && (result_o.virial_yz == '0);

  // a waiting result holds until it is taken
  `PFVA_ASSERT(res_hold, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(result_o)))
  // a result carries forces or a virial, never both
  `PFVA_ASSERT(res_one_kind, clk_i, rst_ni, !empty |-> (force_zero || virial_zero))
  // straight out of reset nothing waits and the store sweep holds off input
  `PFVA_ASSERT_NR(reset_quiet, clk_i, $rose(rst_ni) |-> (empty && full))

endmodule

bind pair_force_virial_accumulator_unit pfva_checker u_pfva_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

`default_nettype wire

FILE: test/pfva_result_checker.sv
// checker that predicts and compares every result of the force and virial accumulator
module pfva_result_checker #(
  parameter int ATOM_COUNT = pfva_pkg::ATOM_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  logic                full,
  input  pfva_pkg::in_item_t  item_i,
  input  logic                empty,
  input  logic                pop,
  input  pfva_pkg::out_item_t result_o,
  output int                  fail_count_o,
  output int                  pending_o
);
  import pfva_pkg::*;

  localparam longint FORCE_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint FORCE_LO = -FORCE_HI - 1;

  logic signed [FORCE_W-1:0] fx_store [ATOM_COUNT];
  logic signed [FORCE_W-1:0] fy_store [ATOM_COUNT];
  logic signed [FORCE_W-1:0] fz_store [ATOM_COUNT];
  logic signed [VIR_W-1:0]   virial_acc [VIR_N];
  logic signed [FORCE_W-1:0] csum_x, csum_y, csum_z;

  out_item_t expected_results [$];
  int        fails;
  int        pending;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  initial begin
    for (int i = 0; i < ATOM_COUNT; i++) begin
      fx_store[i] = '0;
      fy_store[i] = '0;
      fz_store[i] = '0;
    end
    for (int i = 0; i < VIR_N; i++) begin
      virial_acc[i] = '0;
    end
    csum_x  = '0;
    csum_y  = '0;
    csum_z  = '0;
    fails   = 0;
    pending = 0;
  end

  function automatic logic signed [FORCE_W-1:0] clip_force(input longint v);
    if (v > FORCE_HI) return FORCE_HI[FORCE_W-1:0];
    if (v < FORCE_LO) return FORCE_LO[FORCE_W-1:0];
    return v[FORCE_W-1:0];
  endfunction

  // a - b, pinned to the 64-bit range when the signs say it wrapped
  function automatic logic signed [VIR_W-1:0] virial_minus(
    input logic signed [VIR_W-1:0] a,
    input longint                  b
  );
    logic signed [VIR_W-1:0] r;
    r = a - b;
    if (a[VIR_W-1] != b[63] && r[VIR_W-1] != a[VIR_W-1]) begin
      r = a[VIR_W-1] ? {1'b1, {(VIR_W-1){1'b0}}} : {1'b0, {(VIR_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic out_item_t predict_result(input in_item_t it);
    out_item_t r;
    int        a;
    int        c;
    longint    gx, gy, gz, ddx, ddy, ddz;
    r   = '0;
    a   = int'(it.atom_index);
    c   = int'(it.center_index);
    gx  = longint'(it.grad_x);
    gy  = longint'(it.grad_y);
    gz  = longint'(it.grad_z);
    ddx = longint'(it.dx);
    ddy = longint'(it.dy);
    ddz = longint'(it.dz);
    case (cmd_e'(it.cmd))
      CMD_NEIGH: begin
        if (a < ATOM_COUNT) begin
          fx_store[a] = clip_force(longint'(fx_store[a]) - gx);
          fy_store[a] = clip_force(longint'(fy_store[a]) - gy);
          fz_store[a] = clip_force(longint'(fz_store[a]) - gz);
        end
        csum_x = clip_force(longint'(csum_x) + gx);
        csum_y = clip_force(longint'(csum_y) + gy);
        csum_z = clip_force(longint'(csum_z) + gz);
        virial_acc[VIR_XX] = virial_minus(virial_acc[VIR_XX], ddx * gx);
        virial_acc[VIR_YY] = virial_minus(virial_acc[VIR_YY], ddy * gy);
        virial_acc[VIR_ZZ] = virial_minus(virial_acc[VIR_ZZ], ddz * gz);
        virial_acc[VIR_XY] = virial_minus(virial_acc[VIR_XY], ddx * gy);
        virial_acc[VIR_XZ] = virial_minus(virial_acc[VIR_XZ], ddx * gz);
        virial_acc[VIR_YZ] = virial_minus(virial_acc[VIR_YZ], ddy * gz);
        // centre update comes after the neighbour one, even on the same atom
        if (it.last) begin
          if (c < ATOM_COUNT) begin
            fx_store[c] = clip_force(longint'(fx_store[c]) + longint'(csum_x));
            fy_store[c] = clip_force(longint'(fy_store[c]) + longint'(csum_y));
            fz_store[c] = clip_force(longint'(fz_store[c]) + longint'(csum_z));
          end
          csum_x = '0;
          csum_y = '0;
          csum_z = '0;
        end
      end
      CMD_FORCE_RD: begin
        if (a < ATOM_COUNT) begin
          r.force_x   = fx_store[a];
          r.force_y   = fy_store[a];
          r.force_z   = fz_store[a];
          fx_store[a] = '0;
          fy_store[a] = '0;
          fz_store[a] = '0;
        end
      end
      CMD_VIRIAL_RD: begin
        r.virial_xx = virial_acc[VIR_XX];
        r.virial_yy = virial_acc[VIR_YY];
        r.virial_zz = virial_acc[VIR_ZZ];
        r.virial_xy = virial_acc[VIR_XY];
        r.virial_xz = virial_acc[VIR_XZ];
        r.virial_yz = virial_acc[VIR_YZ];
        for (int k = 0; k < VIR_N; k++) begin
          virial_acc[k] = '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : watch
    out_item_t want;
    if (rst_ni) begin
      if (push && !full) begin
        expected_results.push_back(predict_result(item_i));
      end
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          fails++;
          $display("%0t: result with nothing outstanding, expected none, actual %h",
                   $time, result_o);
        end else begin
          want = expected_results.pop_front();
          check_field("force_x",   64'(want.force_x),   64'(result_o.force_x));
          check_field("force_y",   64'(want.force_y),   64'(result_o.force_y));
          check_field("force_z",   64'(want.force_z),   64'(result_o.force_z));
          check_field("virial_xx", want.virial_xx, result_o.virial_xx);
          check_field("virial_yy", want.virial_yy, result_o.virial_yy);
          check_field("virial_zz", want.virial_zz, result_o.virial_zz);
          check_field("virial_xy", want.virial_xy, result_o.virial_xy);
          check_field("virial_xz", want.virial_xz, result_o.virial_xz);
          check_field("virial_yz", want.virial_yz, result_o.virial_yz);
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

FILE: test/tb_pair_force_virial_accumulator_unit.sv
// testbench top of the force and virial accumulator: stimulus, idling and verdict
module tb_pair_force_virial_accumulator_unit;
  import pfva_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  item_i;
  logic      empty;
  logic      pop;
  out_item_t result_o;

  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic hold_req;
  int   stall_cycles;

  pair_force_virial_accumulator_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_o)
  );

  pfva_result_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random pops, plus a long hold-off whenever hold_req toggles
  initial begin : receiver
    int   hold_left;
    logic hold_seen;
    pop       = 1'b0;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // covers the clearing sweep after reset and the long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic logic [31:0] rand_q16();
    int v;
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom();
      default: begin
        v = int'($urandom_range(2097152)) - 1048576;
        return v;
      end
    endcase
  endfunction

  // mostly a small set of atoms so that forces build up before they are read
  function automatic logic [IDX_W-1:0] pick_atom();
    if ($urandom_range(99) < 85) return IDX_W'($urandom_range(15));
    return IDX_W'($urandom_range(IDX_SPAN - 1));
  endfunction

  function automatic in_item_t noise_item(input cmd_e cmd);
    in_item_t it;
    it.cmd          = cmd;
    it.dx           = $urandom();
    it.dy           = $urandom();
    it.dz           = $urandom();
    it.grad_x       = $urandom();
    it.grad_y       = $urandom();
    it.grad_z       = $urandom();
    it.atom_index   = IDX_W'($urandom_range(IDX_SPAN - 1));
    it.center_index = IDX_W'($urandom_range(IDX_SPAN - 1));
    it.last         = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic in_item_t neigh_item(input logic [IDX_W-1:0] atom,
                                          input logic [IDX_W-1:0] centre,
                                          input logic is_last);
    in_item_t it;
    it.cmd          = CMD_NEIGH;
    it.dx           = rand_q16();
    it.dy           = rand_q16();
    it.dz           = rand_q16();
    it.grad_x       = rand_q16();
    it.grad_y       = rand_q16();
    it.grad_z       = rand_q16();
    it.atom_index   = atom;
    it.center_index = centre;
    it.last         = is_last;
    return it;
  endfunction

  function automatic in_item_t read_item(input cmd_e cmd, input logic [IDX_W-1:0] atom);
    in_item_t it;
    it            = noise_item(cmd);
    it.atom_index = atom;
    return it;
  endfunction

  function automatic in_item_t uniform_neigh(input logic [31:0] d, input logic [31:0] g,
                                             input logic [IDX_W-1:0] atom,
                                             input logic [IDX_W-1:0] centre,
                                             input logic is_last);
    in_item_t it;
    it.cmd          = CMD_NEIGH;
    it.dx           = d;
    it.dy           = d;
    it.dz           = d;
    it.grad_x       = g;
    it.grad_y       = g;
    it.grad_z       = g;
    it.atom_index   = atom;
    it.center_index = centre;
    it.last         = is_last;
    return it;
  endfunction

  // entered and left at a falling edge; push stays high into the next item
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push   <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_random(input int n_items);
    int               sent;
    int               pick;
    int               len;
    logic [IDX_W-1:0] centre;
    logic             close_list;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        len        = $urandom_range(6, 1);
        centre     = pick_atom();
        // now and then a list that never gets its last item
        close_list = ($urandom_range(19) != 0);
        for (int j = 0; j < len; j++) begin
          send_item(neigh_item(pick_atom(), centre, close_list && (j == len - 1)));
          sent++;
        end
      end else if (pick < 75) begin
        send_item(read_item(CMD_FORCE_RD, pick_atom()));
        sent++;
      end else if (pick < 85) begin
        send_item(noise_item(CMD_VIRIAL_RD));
        sent++;
      end else if (pick < 90) begin
        send_item(noise_item(CMD_NONE));
        sent++;
      end else begin
        send_item(noise_item(CMD_NEIGH));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    push          = 1'b0;
    item_i        = '0;
    hold_req      = 1'b0;
    stall_cycles  = 0;
    send_idle_pct = 24;
    recv_idle_pct = 73;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reads straight after reset
    send_item(read_item(CMD_FORCE_RD, 12'd0));
    send_item(noise_item(CMD_VIRIAL_RD));
    // field extremes, top and bottom atom, a closed list on centre 0
    send_item(uniform_neigh(32'h7FFF_FFFF, 32'h7FFF_FFFF, 12'd4095, 12'd0, 1'b0));
    send_item(uniform_neigh(32'h8000_0000, 32'h8000_0000, 12'd1, 12'd0, 1'b1));
    send_item(read_item(CMD_FORCE_RD, 12'd4095));
    send_item(read_item(CMD_FORCE_RD, 12'd0));
    send_item(read_item(CMD_FORCE_RD, 12'd1));
    // neighbour equal to its own centre
    send_item(neigh_item(12'd5, 12'd5, 1'b1));
    send_item(read_item(CMD_FORCE_RD, 12'd5));
    send_item(noise_item(CMD_VIRIAL_RD));
    // virial driven past its negative limit, then past its positive one
    send_item(uniform_neigh(32'h8000_0000, 32'h8000_0000, 12'd7, 12'd4095, 1'b0));
    send_item(uniform_neigh(32'h8000_0000, 32'h8000_0000, 12'd7, 12'd4095, 1'b0));
    send_item(uniform_neigh(32'h8000_0000, 32'h8000_0000, 12'd7, 12'd4095, 1'b1));
    send_item(noise_item(CMD_VIRIAL_RD));
    send_item(uniform_neigh(32'h8000_0000, 32'h7FFF_FFFF, 12'd8, 12'd4095, 1'b0));
    send_item(uniform_neigh(32'h8000_0000, 32'h7FFF_FFFF, 12'd8, 12'd4095, 1'b0));
    send_item(uniform_neigh(32'h8000_0000, 32'h7FFF_FFFF, 12'd8, 12'd4095, 1'b1));
    send_item(noise_item(CMD_VIRIAL_RD));
    // last set at random on commands that must ignore it, and the unused command
    send_item(read_item(CMD_FORCE_RD, 12'd4095));
    send_item(noise_item(CMD_NONE));
    send_item(noise_item(CMD_NONE));
    send_item(read_item(CMD_FORCE_RD, 12'd7));
    send_item(read_item(CMD_FORCE_RD, 12'd8));

    run_random(280);
    send_idle_pct = 73;
    recv_idle_pct = 24;
    run_random(280);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // receiver backs off while items keep coming, so the block fills up
    hold_req = ~hold_req;
    run_random(290);
    push <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
